FILE: src/lcdns_pkg.sv
package lcdns_pkg;

    // Operation codes on the result channel
    localparam logic [2:0] OP_NIBBLE = 3'd0;
    localparam logic [2:0] OP_WAIT   = 3'd1;
    localparam logic [2:0] OP_BUSY   = 3'd2;
    localparam logic [2:0] OP_RESET  = 3'd3;
    localparam logic [2:0] OP_LIGHT  = 3'd4;

    // Request kinds on the input channel
    localparam logic [2:0] REQ_PUTCHAR = 3'd0;
    localparam logic [2:0] REQ_GOTO    = 3'd1;
    localparam logic [2:0] REQ_CLRLINE = 3'd2;
    localparam logic [2:0] REQ_CLRSCR  = 3'd3;
    localparam logic [2:0] REQ_INIT    = 3'd4;
    localparam logic [2:0] REQ_LIGHT   = 3'd5;

    localparam int DEF_LINE_COLUMNS = 20;
    localparam int CLEAR_MAX        = 20;
    localparam int BLANK_W          = 5;
    localparam int STEP_W           = 5;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0]  CHAR_FF     = 8'h0C;
    localparam logic [7:0]  CHAR_NL     = 8'h0A;
    localparam logic [7:0]  CHAR_BLANK  = 8'h20;
    localparam logic [7:0]  CMD_SETADDR = 8'h80;
    localparam logic [7:0]  LINE2_BASE  = 8'h40;
    localparam logic [7:0]  CMD_CLEAR   = 8'h01;
    localparam logic [15:0] US_CLEAR    = 16'd2000;

    typedef enum logic [1:0] {
        CMD_BYTES,
        CMD_INIT,
        CMD_LIGHT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               rs;
        logic [7:0]         data;
        logic [BLANK_W-1:0] blanks;
        logic               tail_wait;
        logic               model;
        logic               light;
    } desc_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        rs;
        logic [3:0]  nibble;
        logic [15:0] wait_us;
        logic        last;
    } op_t;

    function automatic op_t make_op(logic [2:0] kind, logic rs, logic [3:0] nib,
                                    logic [15:0] us, logic last);
        op_t o;
        o.kind    = kind;
        o.rs      = rs;
        o.nibble  = nib;
        o.wait_us = us;
        o.last    = last;
        return o;
    endfunction

    function automatic op_t nib_op(logic [3:0] nib, logic last);
        return make_op(OP_NIBBLE, 1'b0, nib, 16'd0, last);
    endfunction

    function automatic op_t wait_op(logic [15:0] us, logic last);
        return make_op(OP_WAIT, 1'b0, 4'd0, us, last);
    endfunction

    // Power-up run, one entry per step, for both controller models
    function automatic op_t init_rom(logic model, logic [STEP_W-1:0] step);
        op_t o;
        o = nib_op(4'h0, 1'b1);
        if (model) begin
            case (step)
                5'd0:  o = make_op(OP_RESET, 1'b0, 4'd0, 16'd200, 1'b0);
                5'd1:  o = wait_op(16'd50000, 1'b0);
                5'd2:  o = nib_op(4'h3, 1'b0);
                5'd3:  o = wait_op(16'd2000, 1'b0);
                5'd4:  o = nib_op(4'h3, 1'b0);
                5'd5:  o = wait_op(16'd30, 1'b0);
                5'd6:  o = nib_op(4'h3, 1'b0);
                5'd7:  o = wait_op(16'd30, 1'b0);
                5'd8:  o = nib_op(4'h2, 1'b0);
                5'd9:  o = wait_op(16'd30, 1'b0);
                5'd10: o = nib_op(4'h2, 1'b0);
                5'd11: o = nib_op(4'h8, 1'b0);
                5'd12: o = wait_op(16'd30, 1'b0);
                5'd13: o = nib_op(4'h0, 1'b0);
                5'd14: o = nib_op(4'h0, 1'b0);
                5'd15: o = wait_op(16'd30, 1'b0);
                5'd16: o = nib_op(4'h0, 1'b0);
                5'd17: o = nib_op(4'hC, 1'b0);
                5'd18: o = wait_op(16'd30, 1'b0);
                5'd19: o = nib_op(4'h0, 1'b0);
                5'd20: o = nib_op(4'h6, 1'b0);
                default: o = wait_op(16'd30, 1'b1);
            endcase
        end else begin
            case (step)
                5'd0:  o = wait_op(16'd50000, 1'b0);
                5'd1:  o = nib_op(4'h2, 1'b0);
                5'd2:  o = nib_op(4'h8, 1'b0);
                5'd3:  o = nib_op(4'h2, 1'b0);
                5'd4:  o = nib_op(4'h8, 1'b0);
                5'd5:  o = wait_op(16'd40, 1'b0);
                5'd6:  o = nib_op(4'h0, 1'b0);
                5'd7:  o = nib_op(4'hC, 1'b0);
                5'd8:  o = wait_op(16'd40, 1'b0);
                5'd9:  o = nib_op(4'h0, 1'b0);
                5'd10: o = nib_op(4'h1, 1'b0);
                5'd11: o = wait_op(16'd2000, 1'b0);
                5'd12: o = nib_op(4'h0, 1'b0);
                default: o = nib_op(4'h6, 1'b1);
            endcase
        end
        return o;
    endfunction

endpackage

FILE: src/lcdns_front.sv
module lcdns_front #(
    parameter int LINE_COLUMNS = lcdns_pkg::DEF_LINE_COLUMNS
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_req_type,
    input  logic [7:0]        s_char_code,
    input  logic [5:0]        s_column,
    input  logic [1:0]        s_line_number,
    input  logic              s_backlight_level,
    input  logic              display_model,
    input  logic              q_full,
    output logic              q_push,
    output lcdns_pkg::desc_t  q_desc
);
    import lcdns_pkg::*;

    localparam int BLANKS = (LINE_COLUMNS < CLEAR_MAX) ? LINE_COLUMNS : CLEAR_MAX;

    logic       has_ops;
    logic [7:0] goto_base;
    logic [7:0] goto_addr;
    logic [7:0] clr_base;

    assign goto_base = (s_line_number >= 2'd2) ? LINE2_BASE : 8'h00;
    assign goto_addr = {2'b00, s_column} + goto_base - 8'd1;
    assign clr_base  = (s_line_number == 2'd2) ? LINE2_BASE : 8'h00;

    always_comb begin
        has_ops          = 1'b1;
        q_desc.kind      = CMD_BYTES;
        q_desc.rs        = 1'b0;
        q_desc.data      = 8'h00;
        q_desc.blanks    = '0;
        q_desc.tail_wait = 1'b0;
        q_desc.model     = display_model;
        q_desc.light     = s_backlight_level;
        unique case (s_req_type)
            REQ_PUTCHAR: begin
                if (s_char_code == CHAR_FF || s_char_code == CHAR_NL) begin
                    q_desc.data = CMD_SETADDR | LINE2_BASE;
                end else begin
                    q_desc.rs   = 1'b1;
                    q_desc.data = s_char_code;
                end
            end
            REQ_GOTO: begin
                q_desc.data = CMD_SETADDR | goto_addr;
            end
            REQ_CLRLINE: begin
                has_ops       = (s_line_number == 2'd1) || (s_line_number == 2'd2);
                q_desc.data   = CMD_SETADDR | clr_base;
                q_desc.blanks = BLANK_W'(BLANKS);
            end
            REQ_CLRSCR: begin
                q_desc.data      = CMD_CLEAR;
                q_desc.tail_wait = 1'b1;
            end
            REQ_INIT: begin
                q_desc.kind = CMD_INIT;
            end
            REQ_LIGHT: begin
                q_desc.kind = CMD_LIGHT;
            end
            default: begin
                has_ops = 1'b0;
            end
        endcase
    end

    // Requests with no operations are taken and dropped here
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && has_ops;

endmodule

FILE: src/lcdns_queue.sv
module lcdns_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lcdns_pkg::desc_t  push_desc,
    input  logic              pop,
    output lcdns_pkg::desc_t  head,
    output logic              full,
    output logic              empty
);
    import lcdns_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    desc_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

FILE: src/lcdns_back.sv
module lcdns_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  lcdns_pkg::desc_t  q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_op_kind,
    output logic              m_rs_level,
    output logic [3:0]        m_nibble,
    output logic [15:0]       m_wait_us,
    output logic              m_last_op
);
    import lcdns_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    localparam logic [1:0] PH_BUSY = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    state_t              state_reg, state_next;
    cmd_kind_t           kind_reg, kind_next;
    logic [1:0]          phase_reg, phase_next;
    logic [BLANK_W-1:0]  left_reg, left_next;
    logic [7:0]          byte_reg, byte_next;
    logic                rs_reg, rs_next;
    logic                tail_reg, tail_next;
    logic                model_reg, model_next;
    logic                light_reg, light_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                m_valid_reg, m_valid_next;
    op_t                 out_reg;
    op_t                 cur_op;
    logic                advance;

    always_comb begin
        cur_op = make_op(OP_LIGHT, 1'b0, {3'b000, light_reg}, 16'd0, 1'b1);
        case (kind_reg)
            CMD_BYTES: begin
                case (phase_reg)
                    PH_BUSY: cur_op = make_op(OP_BUSY, 1'b0, 4'd0, 16'd0, 1'b0);
                    PH_HIGH: cur_op = make_op(OP_NIBBLE, rs_reg, byte_reg[7:4], 16'd0, 1'b0);
                    PH_LOW:  cur_op = make_op(OP_NIBBLE, rs_reg, byte_reg[3:0], 16'd0,
                                              (left_reg == '0) && !tail_reg);
                    default: cur_op = wait_op(US_CLEAR, 1'b1);
                endcase
            end
            CMD_INIT: cur_op = init_rom(model_reg, step_reg);
            default:  cur_op = make_op(OP_LIGHT, 1'b0, {3'b000, light_reg}, 16'd0, 1'b1);
        endcase
    end

    assign advance = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        phase_next = phase_reg;
        left_next  = left_reg;
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        tail_next  = tail_reg;
        model_next = model_reg;
        light_next = light_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    state_next = ST_RUN;
                    kind_next  = q_head.kind;
                    phase_next = PH_BUSY;
                    left_next  = q_head.blanks;
                    byte_next  = q_head.data;
                    rs_next    = q_head.rs;
                    tail_next  = q_head.tail_wait;
                    model_next = q_head.model;
                    light_next = q_head.light;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (advance) begin
                    step_next = step_reg + 1'b1;
                    if (cur_op.last) begin
                        state_next = ST_IDLE;
                    end else if (phase_reg == PH_LOW) begin
                        // next blank byte, or the trailing wait
                        if (left_reg != '0) begin
                            left_next  = left_reg - 1'b1;
                            byte_next  = CHAR_BLANK;
                            rs_next    = 1'b1;
                            phase_next = PH_BUSY;
                        end else begin
                            phase_next = PH_TAIL;
                        end
                    end else begin
                        phase_next = phase_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        phase_reg <= phase_next;
        left_reg  <= left_next;
        byte_reg  <= byte_next;
        rs_reg    <= rs_next;
        tail_reg  <= tail_next;
        model_reg <= model_next;
        light_reg <= light_next;
        step_reg  <= step_next;
        if (advance) begin
            out_reg <= cur_op;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_op_kind  = out_reg.kind;
    assign m_rs_level = out_reg.rs;
    assign m_nibble   = out_reg.nibble;
    assign m_wait_us  = out_reg.wait_us;
    assign m_last_op  = out_reg.last;

`ifndef SYNTH
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == ST_RUN)
        else $error("queue popped but sequencer not running");

    a_rs_cmd_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_op_kind != OP_NIBBLE |-> !m_rs_level)
        else $error("register select set on non-nibble operation");

    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_op_kind == OP_WAIT || m_op_kind == OP_RESET) |-> m_wait_us != 16'd0)
        else $error("wait operation with zero duration");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cur_op.last |=> state_reg == ST_IDLE)
        else $error("sequencer kept running after last operation");
`endif

endmodule

FILE: src/char_lcd_nibble_sequencer.sv
// Expands each request for a 4-bit character LCD into a run of low-level operations,
// one per result: nibble write with RS level, wait, wait-until-not-busy, reset pulse or
// backlight; last_op marks the final one. A 4-entry request queue sits between the
// request decoder and the operation sequencer, so s_ready stays high while the queue
// has room, and requests that produce no operations (unknown kinds, clear of line 0
// or 3) are taken and dropped. The sequencer emits one operation per cycle into an
// output register while m_ready is high, and loads each request from the queue in
// its idle state before its operations start. display_model is written through the
// cfg channel (always ready) and is sampled when a request is decoded, so write it
// only while no request is pending.
module char_lcd_nibble_sequencer #(
    parameter int LINE_COLUMNS = lcdns_pkg::DEF_LINE_COLUMNS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_char_code,
    input  logic [5:0]  s_column,
    input  logic [1:0]  s_line_number,
    input  logic        s_backlight_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_op_kind,
    output logic        m_rs_level,
    output logic [3:0]  m_nibble,
    output logic [15:0] m_wait_us,
    output logic        m_last_op
);
    import lcdns_pkg::*;

    logic  display_model_reg, display_model_next;
    logic  q_push, q_pop, q_full, q_empty;
    desc_t push_desc, head_desc;

    assign cfg_ready          = 1'b1;
    assign display_model_next = cfg_valid ? cfg_data : display_model_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            display_model_reg <= 1'b0;
        end else begin
            display_model_reg <= display_model_next;
        end
    end

    lcdns_front #(
        .LINE_COLUMNS(LINE_COLUMNS)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_char_code       (s_char_code),
        .s_column          (s_column),
        .s_line_number     (s_line_number),
        .s_backlight_level (s_backlight_level),
        .display_model     (display_model_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_desc            (push_desc)
    );

    lcdns_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .head      (head_desc),
        .full      (q_full),
        .empty     (q_empty)
    );

    lcdns_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (head_desc),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_op_kind  (m_op_kind),
        .m_rs_level (m_rs_level),
        .m_nibble   (m_nibble),
        .m_wait_us  (m_wait_us),
        .m_last_op  (m_last_op)
    );

endmodule

FILE: sim/char_lcd_nibble_sequencer_tb.sv
module char_lcd_nibble_sequencer_tb;
    import lcdns_pkg::*;

    localparam int LINE_COLS   = DEF_LINE_COLUMNS;
    localparam int HALF_PERIOD = 6;
    localparam int SETTLE      = 80;
    localparam int LONG_HOLD   = 300;
    localparam int IDLE_LIMIT  = 3000;

    // Request kinds the block takes but ignores
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    class lcd_op_scoreboard;
        op_t  pending_ops[$];
        op_t  run_ops[$];
        logic model;
        int   errors;

        function void add_op(logic [2:0] kind, logic rs, logic [3:0] nib, logic [15:0] us);
            op_t o;
            o.kind    = kind;
            o.rs      = rs;
            o.nibble  = nib;
            o.wait_us = us;
            o.last    = 1'b0;
            run_ops.push_back(o);
        endfunction

        function void add_nib(logic [3:0] nib);
            add_op(OP_NIBBLE, 1'b0, nib, 16'd0);
        endfunction

        function void add_wait(logic [15:0] us);
            add_op(OP_WAIT, 1'b0, 4'd0, us);
        endfunction

        function void add_byte(logic rs, logic [7:0] b);
            add_op(OP_BUSY, 1'b0, 4'd0, 16'd0);
            add_op(OP_NIBBLE, rs, b[7:4], 16'd0);
            add_op(OP_NIBBLE, rs, b[3:0], 16'd0);
        endfunction

        function void add_goto(logic [5:0] col, logic [1:0] line);
            logic [7:0] addr;
            // address wraps in 8 bits, column 0 included
            addr = ((line >= 2'd2) ? LINE2_BASE : 8'h00) + {2'b00, col} - 8'd1;
            add_byte(1'b0, CMD_SETADDR | addr);
        endfunction

        function void note_request(logic [2:0] kind, logic [7:0] ch, logic [5:0] col,
                                   logic [1:0] line, logic light);
            op_t tail;
            int  blanks;
            run_ops.delete();
            blanks = (LINE_COLS < CLEAR_MAX) ? LINE_COLS : CLEAR_MAX;
            case (kind)
                REQ_PUTCHAR: begin
                    // form feed and newline jump to the start of line 2
                    if (ch == CHAR_FF || ch == CHAR_NL)
                        add_goto(6'd1, 2'd2);
                    else
                        add_byte(1'b1, ch);
                end
                REQ_GOTO: add_goto(col, line);
                REQ_CLRLINE: begin
                    if (line == 2'd1 || line == 2'd2) begin
                        add_goto(6'd1, line);
                        repeat (blanks) add_byte(1'b1, CHAR_BLANK);
                    end
                end
                REQ_CLRSCR: begin
                    add_byte(1'b0, CMD_CLEAR);
                    add_wait(US_CLEAR);
                end
                REQ_INIT: begin
                    if (model) begin
                        add_op(OP_RESET, 1'b0, 4'd0, 16'd200);
                        add_wait(16'd50000);
                        add_nib(4'h3); add_wait(16'd2000);
                        add_nib(4'h3); add_wait(16'd30);
                        add_nib(4'h3); add_wait(16'd30);
                        add_nib(4'h2); add_wait(16'd30);
                        add_nib(4'h2); add_nib(4'h8); add_wait(16'd30);
                        add_nib(4'h0); add_nib(4'h0); add_wait(16'd30);
                        add_nib(4'h0); add_nib(4'hC); add_wait(16'd30);
                        add_nib(4'h0); add_nib(4'h6); add_wait(16'd30);
                    end else begin
                        add_wait(16'd50000);
                        add_nib(4'h2); add_nib(4'h8); add_nib(4'h2); add_nib(4'h8);
                        add_wait(16'd40);
                        add_nib(4'h0); add_nib(4'hC);
                        add_wait(16'd40);
                        add_nib(4'h0); add_nib(4'h1);
                        add_wait(16'd2000);
                        add_nib(4'h0); add_nib(4'h6);
                    end
                end
                REQ_LIGHT: add_op(OP_LIGHT, 1'b0, {3'b000, light}, 16'd0);
                default: ;
            endcase
            if (run_ops.size() != 0) begin
                tail = run_ops.pop_back();
                tail.last = 1'b1;
                run_ops.push_back(tail);
            end
            foreach (run_ops[i]) pending_ops.push_back(run_ops[i]);
        endfunction

        function void check_op(op_t got);
            op_t want;
            if (pending_ops.size() == 0) begin
                $error("unexpected op: op_kind %0d nibble %0d", got.kind, got.nibble);
                errors++;
                return;
            end
            want = pending_ops.pop_front();
            if (got.kind != want.kind) begin
                $error("op_kind expected %0d actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.rs != want.rs) begin
                $error("rs_level expected %0d actual %0d", want.rs, got.rs);
                errors++;
            end
            if (got.nibble != want.nibble) begin
                $error("nibble expected %0d actual %0d", want.nibble, got.nibble);
                errors++;
            end
            if (got.wait_us != want.wait_us) begin
                $error("wait_us expected %0d actual %0d", want.wait_us, got.wait_us);
                errors++;
            end
            if (got.last != want.last) begin
                $error("last_op expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_req_type;
    logic [7:0]  s_char_code;
    logic [5:0]  s_column;
    logic [1:0]  s_line_number;
    logic        s_backlight_level;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_op_kind;
    logic        m_rs_level;
    logic [3:0]  m_nibble;
    logic [15:0] m_wait_us;
    logic        m_last_op;

    bit hold_req = 1'b0;
    bit quiet    = 1'b0;
    bit tx_gaps  = 1'b1;
    int idle_cycles = 0;

    lcd_op_scoreboard sb = new;

    char_lcd_nibble_sequencer #(
        .LINE_COLUMNS(LINE_COLS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_req_type(s_req_type),
        .s_char_code(s_char_code),
        .s_column(s_column),
        .s_line_number(s_line_number),
        .s_backlight_level(s_backlight_level),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_op_kind(m_op_kind),
        .m_rs_level(m_rs_level),
        .m_nibble(m_nibble),
        .m_wait_us(m_wait_us),
        .m_last_op(m_last_op)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin : op_monitor
        op_t got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.model = cfg_data;
            if (s_valid && s_ready)
                sb.note_request(s_req_type, s_char_code, s_column, s_line_number,
                                s_backlight_level);
            if (m_valid && m_ready) begin
                got.kind    = m_op_kind;
                got.rs      = m_rs_level;
                got.nibble  = m_nibble;
                got.wait_us = m_wait_us;
                got.last    = m_last_op;
                sb.check_op(got);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("char_lcd_nibble_sequencer_tb: FAIL");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, none at the end
    initial begin : op_sink
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_req(logic [2:0] kind, logic [7:0] ch, logic [5:0] col,
                            logic [1:0] line, logic light);
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_req_type        <= kind;
        s_char_code       <= ch;
        s_column          <= col;
        s_line_number     <= line;
        s_backlight_level <= light;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_model(logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stop requests and wait until every pending op has been checked, then let the block settle
    task automatic drain_ops();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_ops.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_random(int count);
        int         pick;
        logic [2:0] kind;
        logic [7:0] ch;
        logic [5:0] col;
        logic [1:0] line;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = REQ_PUTCHAR;
            else if (pick < 60) kind = REQ_GOTO;
            else if (pick < 70) kind = REQ_CLRLINE;
            else if (pick < 78) kind = REQ_CLRSCR;
            else if (pick < 83) kind = REQ_INIT;
            else if (pick < 95) kind = REQ_LIGHT;
            else if (pick < 97) kind = REQ_SPARE_A;
            else                kind = REQ_SPARE_B;
            ch   = 8'($urandom_range(0, 255));
            line = 2'($urandom_range(0, 3));
            col  = 6'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(1, 40));
            if (kind == REQ_PUTCHAR && $urandom_range(0, 9) == 0)
                ch = $urandom_range(0, 1) ? CHAR_FF : CHAR_NL;
            if (kind == REQ_CLRLINE && $urandom_range(0, 3) != 0)
                line = 2'($urandom_range(1, 2));
            send_req(kind, ch, col, line, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        aresetn           = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = 1'b0;
        s_valid           = 1'b0;
        s_req_type        = REQ_PUTCHAR;
        s_char_code       = 8'h00;
        s_column          = 6'd1;
        s_line_number     = 2'd0;
        s_backlight_level = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_model(1'b0);
        send_req(REQ_INIT, 8'h00, 6'd1, 2'd0, 1'b0);
        send_req(REQ_PUTCHAR, 8'h00, 6'd1, 2'd0, 1'b0);
        send_req(REQ_PUTCHAR, 8'hFF, 6'd63, 2'd3, 1'b1);
        send_req(REQ_PUTCHAR, CHAR_FF, 6'd5, 2'd1, 1'b0);
        send_req(REQ_PUTCHAR, CHAR_NL, 6'd5, 2'd1, 1'b0);
        send_req(REQ_PUTCHAR, 8'h41, 6'd5, 2'd1, 1'b0);
        send_req(REQ_GOTO, 8'h00, 6'd1, 2'd0, 1'b0);
        send_req(REQ_GOTO, 8'hFF, 6'd40, 2'd3, 1'b1);
        send_req(REQ_GOTO, 8'h00, 6'd0, 2'd1, 1'b0);
        send_req(REQ_GOTO, 8'h00, 6'd63, 2'd2, 1'b0);
        send_req(REQ_GOTO, 8'h00, 6'd20, 2'd1, 1'b0);
        send_req(REQ_CLRLINE, 8'h00, 6'd1, 2'd0, 1'b0);
        send_req(REQ_CLRLINE, 8'h00, 6'd1, 2'd1, 1'b0);
        send_req(REQ_CLRLINE, 8'h00, 6'd1, 2'd2, 1'b0);
        send_req(REQ_CLRLINE, 8'h00, 6'd1, 2'd3, 1'b0);
        send_req(REQ_CLRSCR, 8'h00, 6'd1, 2'd0, 1'b0);
        send_req(REQ_LIGHT, 8'h00, 6'd1, 2'd0, 1'b1);
        send_req(REQ_LIGHT, 8'hFF, 6'd1, 2'd0, 1'b0);
        send_req(REQ_SPARE_A, 8'hFF, 6'd63, 2'd3, 1'b1);
        send_req(REQ_SPARE_B, 8'h00, 6'd0, 2'd0, 1'b0);
        drain_ops();

        write_model(1'b1);
        send_req(REQ_INIT, 8'h00, 6'd1, 2'd0, 1'b0);
        send_req(REQ_CLRLINE, 8'h00, 6'd1, 2'd2, 1'b0);
        send_req(REQ_PUTCHAR, 8'h7E, 6'd1, 2'd0, 1'b0);
        drain_ops();

        write_model(1'b0);
        send_random(120);
        drain_ops();

        // hold the result side while requests keep coming so the queue backs up
        write_model(1'b1);
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        send_random(40);
        tx_gaps  = 1'b1;
        send_random(100);
        drain_ops();

        write_model(1'($urandom_range(0, 1)));
        send_random(120);
        drain_ops();

        write_model(1'b0);
        quiet   = 1'b1;
        tx_gaps = 1'b0;
        send_random(100);
        drain_ops();

        if (sb.pending_ops.size() != 0) begin
            $error("%0d expected ops never arrived", sb.pending_ops.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("char_lcd_nibble_sequencer_tb: PASS");
        else
            $display("char_lcd_nibble_sequencer_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/lcdns_pkg.sv
src/lcdns_front.sv
src/lcdns_queue.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer.sv
sim/char_lcd_nibble_sequencer_tb.sv
